[rtl/cc20_pkg.sv]
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types and constants for the ChaCha20 stream cipher block: payload
// structs, controller/datapath command and status groups, register indexes.
// ----------------------------------------------------------------------------
package cc20_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned NUM_WORDS = 16;
    localparam int unsigned POS_W     = 4;
    localparam int unsigned ROUND_W   = 5;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [ROUND_W-1:0] LAST_ROUND = 5'd19;

    // The four "expand 32-byte k" constants.
    localparam logic [WORD_W-1:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320_646E;
    localparam logic [WORD_W-1:0] SIGMA_2 = 32'h7962_2D32;
    localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6B20_6574;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_01   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_23   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_45   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_67   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_01 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTER  = 3'd6;

    typedef struct packed {
        logic [31:0] in_data;
        logic [2:0]  valid_bytes;
        logic        end_of_message;
    } item_t;

    typedef struct packed {
        logic [31:0] out_data;
        logic [2:0]  out_valid_bytes;
        logic        out_last;
    } result_t;

    typedef struct packed {
        logic capture;  // latch the accepted input word
        logic load;     // load the working state from key, nonce and counter
        logic step;     // run one half of four parallel quarter-rounds
        logic diag;     // diagonal round when set, column round otherwise
        logic half;     // second half of the quarter-round when set
        logic finish;   // form the keystream block and bump the counter
        logic emit;     // write the result register and advance the position
    } dp_cmd_t;

    typedef struct packed {
        logic pos_zero;
    } dp_status_t;

endpackage

[rtl/cc20_ctrl.sv]
// ----------------------------------------------------------------------------
// cc20_ctrl
// Sequencer for the cipher: accepts a word, runs the 20 rounds when a new
// keystream block is due, and hands the result to the output register.
// ----------------------------------------------------------------------------
module cc20_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    input  cc20_pkg::dp_status_t status,
    output cc20_pkg::dp_cmd_t   cmd
);
    import cc20_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [ROUND_W-1:0] round_reg;
    logic [ROUND_W-1:0] round_next;
    logic               half_reg;
    logic               half_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        half_next  = half_reg;
        cmd        = '0;
        cmd.diag   = round_reg[0];
        cmd.half   = half_reg;
        req_stall  = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    if (status.pos_zero)
                    begin
                        cmd.load   = 1'b1;
                        round_next = '0;
                        half_next  = 1'b0;
                        state_next = ST_ROUND;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_ROUND:
            begin
                cmd.step  = 1'b1;
                half_next = ~half_reg;
                if (half_reg)
                begin
                    round_next = round_reg + 5'd1;
                    if (round_reg == LAST_ROUND)
                    begin
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_FINAL:
            begin
                cmd.finish = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // The result register must be empty or emptying this cycle.
                if (!out_valid_reg || !rsp_stall)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    assign out_valid_next = cmd.emit | (out_valid_reg & rsp_stall);
    assign rsp_valid      = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/cc20_datapath.sv]
// ----------------------------------------------------------------------------
// cc20_datapath
// Key, nonce and counter registers, the 16-word working state with four
// parallel half quarter-round lanes, the keystream block and the result word.
// ----------------------------------------------------------------------------
module cc20_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [63:0]          cfg_data,
    input  cc20_pkg::item_t      req_item,
    output cc20_pkg::result_t    rsp_item,
    input  cc20_pkg::dp_cmd_t    cmd,
    output cc20_pkg::dp_status_t status
);
    import cc20_pkg::*;

    logic [CFG_DATA_W-1:0] key_reg [4];
    logic [CFG_DATA_W-1:0] nonce01_reg;
    logic [WORD_W-1:0]     nonce2_reg;
    logic [WORD_W-1:0]     counter_reg;
    logic [POS_W-1:0]      pos_reg;

    item_t                 hold_reg;
    result_t               rsp_reg;
    result_t               rsp_next;
    logic [WORD_W-1:0]     ws_reg   [NUM_WORDS];
    logic [WORD_W-1:0]     ws_step  [NUM_WORDS];
    logic [WORD_W-1:0]     ks_reg   [NUM_WORDS];
    logic [WORD_W-1:0]     init_w   [NUM_WORDS];

    logic [3:0]            idx_a [4];
    logic [3:0]            idx_b [4];
    logic [3:0]            idx_c [4];
    logic [3:0]            idx_d [4];
    logic [WORD_W-1:0]     sum_a [4];
    logic [WORD_W-1:0]     mix_d [4];
    logic [WORD_W-1:0]     sum_c [4];
    logic [WORD_W-1:0]     mix_b [4];

    logic [WORD_W-1:0]     ks_word;
    logic [WORD_W-1:0]     xor_word;

    // Initial block state from the constants, key, counter and nonce.
    always_comb
    begin
        init_w[0] = SIGMA_0;
        init_w[1] = SIGMA_1;
        init_w[2] = SIGMA_2;
        init_w[3] = SIGMA_3;
        for (int i = 0; i < 4; i++)
        begin
            init_w[4 + 2 * i] = key_reg[i][31:0];
            init_w[5 + 2 * i] = key_reg[i][63:32];
        end
        init_w[12] = counter_reg;
        init_w[13] = nonce01_reg[31:0];
        init_w[14] = nonce01_reg[63:32];
        init_w[15] = nonce2_reg;
    end

    // Four independent lanes, each doing one half of a quarter-round.
    // Diagonal rounds rotate the b, c and d rows by one, two and three lanes.
    always_comb
    begin
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            ws_step[i] = ws_reg[i];
        end
        for (int j = 0; j < 4; j++)
        begin
            idx_a[j] = {2'b00, 2'(j)};
            idx_b[j] = {2'b01, 2'(j + (cmd.diag ? 1 : 0))};
            idx_c[j] = {2'b10, 2'(j + (cmd.diag ? 2 : 0))};
            idx_d[j] = {2'b11, 2'(j + (cmd.diag ? 3 : 0))};

            sum_a[j] = ws_reg[idx_a[j]] + ws_reg[idx_b[j]];
            mix_d[j] = ws_reg[idx_d[j]] ^ sum_a[j];
            if (cmd.half)
            begin
                mix_d[j] = {mix_d[j][23:0], mix_d[j][31:24]};
            end
            else
            begin
                mix_d[j] = {mix_d[j][15:0], mix_d[j][31:16]};
            end
            sum_c[j] = ws_reg[idx_c[j]] + mix_d[j];
            mix_b[j] = ws_reg[idx_b[j]] ^ sum_c[j];
            if (cmd.half)
            begin
                mix_b[j] = {mix_b[j][24:0], mix_b[j][31:25]};
            end
            else
            begin
                mix_b[j] = {mix_b[j][19:0], mix_b[j][31:20]};
            end

            ws_step[idx_a[j]] = sum_a[j];
            ws_step[idx_b[j]] = mix_b[j];
            ws_step[idx_c[j]] = sum_c[j];
            ws_step[idx_d[j]] = mix_d[j];
        end
    end

    // Result word: bytes at or beyond the valid count are forced to zero.
    assign ks_word  = ks_reg[pos_reg];
    assign xor_word = hold_reg.in_data ^ ks_word;

    always_comb
    begin
        rsp_next.out_valid_bytes = hold_reg.valid_bytes;
        rsp_next.out_last        = hold_reg.end_of_message;
        for (int i = 0; i < 4; i++)
        begin
            rsp_next.out_data[8 * i +: 8] =
                (hold_reg.valid_bytes > 3'(i)) ? xor_word[8 * i +: 8] : 8'h00;
        end
    end

    // Configuration and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
            nonce01_reg <= '0;
            nonce2_reg  <= '0;
            counter_reg <= 32'd1;
            pos_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_KEY_01:   key_reg[0]  <= cfg_data;
                    CFG_KEY_23:   key_reg[1]  <= cfg_data;
                    CFG_KEY_45:   key_reg[2]  <= cfg_data;
                    CFG_KEY_67:   key_reg[3]  <= cfg_data;
                    CFG_NONCE_01: nonce01_reg <= cfg_data;
                    CFG_NONCE_2:  nonce2_reg  <= cfg_data[31:0];
                    CFG_COUNTER:  counter_reg <= cfg_data[31:0];
                    default:      ;
                endcase
            end
            else if (cmd.finish)
            begin
                counter_reg <= counter_reg + 32'd1;
            end

            if (cmd.emit)
            begin
                pos_reg <= hold_reg.end_of_message ? '0 : pos_reg + 4'd1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            hold_reg <= req_item;
        end
        if (cmd.emit)
        begin
            rsp_reg <= rsp_next;
        end
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            if (cmd.load)
            begin
                ws_reg[i] <= init_w[i];
            end
            else if (cmd.step)
            begin
                ws_reg[i] <= ws_step[i];
            end
            if (cmd.finish)
            begin
                ks_reg[i] <= init_w[i] + ws_reg[i];
            end
        end
    end

    assign rsp_item        = rsp_reg;
    assign status.pos_zero = (pos_reg == '0);

endmodule

[rtl/chacha20_stream_cipher_top.sv]
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_top: ChaCha20 (20 rounds) word cipher, encrypt/decrypt.
// A word inside a block goes from the input hold register straight to the output register.
// A word at block start first passes 40 half quarter-rounds, 1 add and
// 1 output register. A held result adds its stall.
// The half quarter-round unit (four lanes) sets the rate; one word at a time.
// Reset clears key and nonce to zero, the block counter to one, position zero.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_data,
    input  logic              req_valid,
    output logic              req_stall,
    input  cc20_pkg::item_t   req_item,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output cc20_pkg::result_t rsp_item
);
    import cc20_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    cc20_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    cc20_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_item  (req_item),
        .rsp_item  (rsp_item),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
